/* hdl/irpfd_pkg.sv */
// Package for the IR remote pulse-frame decoder.
// Frame geometry, key command words and key matching function.
// No dependencies.
package irpfd_pkg;

    localparam int FRAME_EDGES = 34;
    localparam int CODE_BITS   = 16;
    localparam int FIRST_CODE_EDGE = (FRAME_EDGES > CODE_BITS) ? (FRAME_EDGES - CODE_BITS) : 0;

    localparam int TICKS_W = 16;
    localparam int WORD_W  = 16;
    localparam int KEY_W   = 4;
    localparam int IDX_W   = 6;
    localparam int MATCH_W = (CODE_BITS > WORD_W) ? CODE_BITS : WORD_W;

    localparam int KEY_COUNT = 11;

    typedef logic [TICKS_W-1:0]   t_ticks;
    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [KEY_W-1:0]     t_key_code;
    typedef logic [IDX_W-1:0]     t_edge_idx;
    typedef logic [CODE_BITS-1:0] t_code_bits;

    localparam t_key_code KEY_NONE = t_key_code'(0);

    localparam t_ticks TICKS_ZERO_BIT = t_ticks'(1);
    localparam t_ticks TICKS_ONE_BIT  = t_ticks'(2);

    // Command words for keys 1..11 (digits 1-9, enter, last/delete)
    localparam t_word KEY_WORDS [KEY_COUNT] = '{
        16'hFE01, 16'hFD02, 16'hFC03, 16'hFB04, 16'hFA05, 16'hF906,
        16'hF807, 16'hF708, 16'hF609, 16'hE817, 16'hBF40
    };

    function automatic t_key_code match_key(input t_code_bits bits);
        t_key_code code;
        code = KEY_NONE;
        for (int n = 0; n < KEY_COUNT; n++) begin
            if (MATCH_W'(bits) == MATCH_W'(KEY_WORDS[n])) begin
                code = t_key_code'(n + 1);
            end
        end
        return code;
    endfunction

endpackage

/* hdl/irpfd_if.sv */
// Valid/ready channel interfaces for the IR remote pulse-frame decoder.
// Depends on irpfd_pkg for payload types.
interface irpfd_in_if;
    logic                 valid;
    logic                 ready;
    irpfd_pkg::t_ticks    edge_ticks;

    modport source (output valid, output edge_ticks, input ready);
    modport sink   (input valid, input edge_ticks, output ready);
endinterface

interface irpfd_out_if;
    logic                 valid;
    logic                 ready;
    irpfd_pkg::t_key_code key_code;
    irpfd_pkg::t_word     command_word;
    logic                 frame_invalid;

    modport source (output valid, output key_code, output command_word,
                    output frame_invalid, input ready);
    modport sink   (input valid, input key_code, input command_word,
                    input frame_invalid, output ready);
endinterface

/* hdl/ir_remote_pulse_frame_decoder.sv */
// IR remote pulse-frame decoder: takes one edge interval per transfer and, on
// the last of each 34-transition frame, returns the 16-bit command word, its
// key code and an invalid flag. One interval is taken every cycle unless the
// result register is stalled; the final edge is captured in the input
// register, then its result in the result register. Only a stalled result
// register holds off input. Depends on irpfd_pkg and irpfd_if.
module ir_remote_pulse_frame_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    irpfd_in_if.sink   i_in,
    irpfd_out_if.source o_out
);
    import irpfd_pkg::*;

    logic       r_in_valid;
    t_ticks     r_in_ticks;

    t_edge_idx  r_edge_idx,  n_edge_idx;
    t_code_bits r_bits,      n_bits;
    logic       r_bad,       n_bad;

    logic       r_out_valid;
    t_key_code  r_key_code;
    t_word      r_word;
    logic       r_invalid;

    logic       advance;
    logic       in_code;
    logic       last_edge;
    logic       tick_ok;
    logic       bad_now;
    t_edge_idx  pos;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign in_code   = r_edge_idx >= t_edge_idx'(FIRST_CODE_EDGE);
    assign last_edge = r_edge_idx >= t_edge_idx'(FRAME_EDGES - 1);
    assign pos       = r_edge_idx - t_edge_idx'(FIRST_CODE_EDGE);
    assign tick_ok   = (r_in_ticks == TICKS_ZERO_BIT) || (r_in_ticks == TICKS_ONE_BIT);
    assign bad_now   = r_bad || (in_code && !tick_ok);

    always_comb begin
        n_bits = r_bits;
        for (int k = 0; k < CODE_BITS; k++) begin
            if (in_code && r_in_ticks == TICKS_ONE_BIT && pos == t_edge_idx'(k)) begin
                n_bits[k] = 1'b1;
            end
        end
        n_bad      = bad_now;
        n_edge_idx = r_edge_idx + t_edge_idx'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_edge_idx  <= '0;
            r_bits      <= '0;
            r_bad       <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance && last_edge) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                if (last_edge) begin
                    r_edge_idx  <= '0;
                    r_bits      <= '0;
                    r_bad       <= 1'b0;
                end else begin
                    r_edge_idx  <= n_edge_idx;
                    r_bits      <= n_bits;
                    r_bad       <= n_bad;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_ticks <= i_in.edge_ticks;
        end
        if (advance && last_edge) begin
            r_key_code <= n_bad ? KEY_NONE : match_key(n_bits);
            r_word     <= t_word'(MATCH_W'(n_bits));
            r_invalid  <= n_bad;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.key_code      = r_key_code;
    assign o_out.command_word  = r_word;
    assign o_out.frame_invalid = r_invalid;

endmodule
